/* hw/rtl/hffp_pkg.sv */
package hffp_pkg;

   localparam int unsigned MAX_FIELDS = 8;
   localparam logic [2:0] LAST_FIELD_INDEX = 3'(MAX_FIELDS - 1);

   localparam logic [7:0] CHAR_START = 8'h2A;
   localparam logic [7:0] CHAR_END   = 8'h23;
   localparam logic [7:0] CHAR_SEP   = 8'h2C;

   localparam logic [7:0] EXPECTED_LENGTH_RESET = 8'd38;
   localparam logic [2:0] SWAP_FIELD_RESET      = 3'd6;

   typedef enum logic {
      CSR_EXPECTED_LENGTH = 1'b0,
      CSR_SWAP_FIELD      = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_digit_type;

   function automatic hex_digit_type hex_digit(input logic [7:0] c);
      hex_digit_type d;
      d.valid = 1'b1;
      if (c inside {[8'h30:8'h39]}) begin
         d.value = 4'(c - 8'h30);
      end else if (c inside {[8'h41:8'h46]}) begin
         d.value = 4'(c - 8'h37);
      end else if (c inside {[8'h61:8'h66]}) begin
         d.value = 4'(c - 8'h57);
      end else begin
         d.valid = 1'b0;
         d.value = 4'd0;
      end
      return d;
   endfunction

endpackage

/* hw/rtl/hex_field_frame_parser.sv */
// Hex field frame parser.
// Input channel (req_): one received byte per word; the word is taken at a
// rising edge with req_valid high and req_stall low. Bytes outside a frame
// are dropped until '*' opens one; ',' and '#' close fields.
// Result channel (rsp_): one word per field after the header closed by ','
// up to index 7; one status word at '#' in any case, with the field it closes.
// A word is taken when rsp_valid is high and rsp_stall is low.
// Configuration (csr_): csr_index 0 writes expected_length, 1 writes
// swap_field_index; csr_ready is always high. Write only while idle.
// Throughput: one byte per cycle while no result waits under rsp_stall;
// each byte passes the input register and one step of compare and shift-or
// logic into the result register, which drives rsp_.
// Stall: while rsp_stall holds a waiting result, the byte in the input
// register holds and req_stall rises; nothing is lost.
// Reset: synchronous, active high; empties both registers, returns to
// hunting for '*' and restores the register reset values (38 and 6).
module hex_field_frame_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_field_index,
   output logic [31:0] rsp_field_value,
   output logic        rsp_field_bad,
   output logic        rsp_last_field,
   output logic        rsp_length_error,
   output logic        rsp_count_error,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [7:0]  csr_data
);

   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;

   logic [7:0]  expected_length_ff;
   logic [2:0]  swap_field_ff;

   logic        in_frame_ff,  in_frame_in;
   logic [2:0]  field_num_ff, field_num_in;
   logic [31:0] acc_ff,       acc_in;
   logic        char_err_ff,  char_err_in;
   logic [7:0]  byte_cnt_ff,  byte_cnt_in;
   logic        excess_ff,    excess_in;

   logic        rsp_valid_ff;
   logic [2:0]  rsp_index_ff,  rsp_index_in;
   logic [31:0] rsp_value_ff,  rsp_value_in;
   logic        rsp_bad_ff,    rsp_bad_in;
   logic        rsp_last_ff,   rsp_last_in;
   logic        rsp_len_ff,    rsp_len_in;
   logic        rsp_cnt_ff,    rsp_cnt_in;
   logic        emit;

   logic        out_free;
   logic        work;
   hffp_pkg::hex_digit_type digit;
   logic [31:0] field_val;
   logic        real_field;
   logic        is_last;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign work      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign csr_ready = 1'b1;

   always_comb begin
      digit = hffp_pkg::hex_digit(in_byte_ff);
      field_val = char_err_ff ? 32'd0 : acc_ff;
      if (swap_field_ff != 3'd0 && field_num_ff == swap_field_ff) begin
         field_val = {16'd0, field_val[7:0], field_val[15:8]};
      end
      real_field = !excess_ff && field_num_ff != 3'd0;
      is_last    = in_byte_ff == hffp_pkg::CHAR_END;

      in_frame_in  = in_frame_ff;
      field_num_in = field_num_ff;
      acc_in       = acc_ff;
      char_err_in  = char_err_ff;
      byte_cnt_in  = byte_cnt_ff;
      excess_in    = excess_ff;
      emit         = 1'b0;

      byte_cnt_in = (byte_cnt_ff == 8'hFF) ? byte_cnt_ff : byte_cnt_ff + 8'd1;

      rsp_index_in = real_field ? field_num_ff : 3'd0;
      rsp_value_in = real_field ? field_val : 32'd0;
      rsp_bad_in   = real_field && char_err_ff;
      rsp_last_in  = is_last;
      rsp_len_in   = is_last && byte_cnt_in != expected_length_ff;
      rsp_cnt_in   = is_last && excess_ff;

      if (in_byte_ff == hffp_pkg::CHAR_START) begin
         in_frame_in  = 1'b1;
         field_num_in = 3'd0;
         acc_in       = 32'd0;
         char_err_in  = 1'b0;
         byte_cnt_in  = 8'd1;
         excess_in    = 1'b0;
      end else if (!in_frame_ff) begin
         byte_cnt_in = byte_cnt_ff;
      end else if (is_last) begin
         emit        = 1'b1;
         in_frame_in = 1'b0;
      end else if (in_byte_ff == hffp_pkg::CHAR_SEP) begin
         emit = real_field;
         if (!excess_ff) begin
            if (field_num_ff >= hffp_pkg::LAST_FIELD_INDEX) begin
               excess_in = 1'b1;
            end else begin
               field_num_in = field_num_ff + 3'd1;
            end
         end
         acc_in      = 32'd0;
         char_err_in = 1'b0;
      end else if (!digit.valid) begin
         char_err_in = 1'b1;
      end else begin
         acc_in = {acc_ff[27:0], digit.value};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         in_frame_ff        <= 1'b0;
         field_num_ff       <= 3'd0;
         acc_ff             <= 32'd0;
         char_err_ff        <= 1'b0;
         byte_cnt_ff        <= 8'd0;
         excess_ff          <= 1'b0;
         expected_length_ff <= hffp_pkg::EXPECTED_LENGTH_RESET;
         swap_field_ff      <= hffp_pkg::SWAP_FIELD_RESET;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (out_free) begin
            rsp_valid_ff <= work && emit;
         end
         if (work) begin
            in_frame_ff  <= in_frame_in;
            field_num_ff <= field_num_in;
            acc_ff       <= acc_in;
            char_err_ff  <= char_err_in;
            byte_cnt_ff  <= byte_cnt_in;
            excess_ff    <= excess_in;
         end
         if (csr_valid) begin
            case (hffp_pkg::csr_index_type'(csr_index))
               hffp_pkg::CSR_EXPECTED_LENGTH: expected_length_ff <= csr_data;
               hffp_pkg::CSR_SWAP_FIELD:      swap_field_ff      <= csr_data[2:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_rx_byte;
      end
      if (work && emit) begin
         rsp_index_ff <= rsp_index_in;
         rsp_value_ff <= rsp_value_in;
         rsp_bad_ff   <= rsp_bad_in;
         rsp_last_ff  <= rsp_last_in;
         rsp_len_ff   <= rsp_len_in;
         rsp_cnt_ff   <= rsp_cnt_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_field_index  = rsp_index_ff;
   assign rsp_field_value  = rsp_value_ff;
   assign rsp_field_bad    = rsp_bad_ff;
   assign rsp_last_field   = rsp_last_ff;
   assign rsp_length_error = rsp_len_ff;
   assign rsp_count_error  = rsp_cnt_ff;

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps

typedef struct packed {
   logic [2:0]  index;
   logic [31:0] value;
   logic        bad;
   logic        last;
   logic        length_err;
   logic        count_err;
} field_word_type;

class field_word_checker;
   logic [7:0]  expected_length;
   logic [2:0]  swap_field;
   logic        in_frame;
   logic [2:0]  field_number;
   logic [31:0] hex_acc;
   logic        char_err;
   logic [7:0]  byte_count;
   logic        excess;
   field_word_type expected_words[$];
   int unsigned mismatches;

   function new();
      expected_length = hffp_pkg::EXPECTED_LENGTH_RESET;
      swap_field      = hffp_pkg::SWAP_FIELD_RESET;
      in_frame        = 1'b0;
      field_number    = 3'd0;
      hex_acc         = 32'd0;
      char_err        = 1'b0;
      byte_count      = 8'd0;
      excess          = 1'b0;
      mismatches      = 0;
   endfunction

   function logic [4:0] hex_value(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
      if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h37)};
      if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h57)};
      return 5'd0;
   endfunction

   function void write_reg(input hffp_pkg::csr_index_type idx, input logic [7:0] data);
      if (idx == hffp_pkg::CSR_EXPECTED_LENGTH) begin
         expected_length = data;
      end else begin
         swap_field = data[2:0];
      end
   endfunction

   function void take_byte(input logic [7:0] c);
      logic [4:0]     digit;
      logic           emitted;
      logic [31:0]    v;
      field_word_type w;
      if (c == hffp_pkg::CHAR_START) begin
         in_frame     = 1'b1;
         field_number = 3'd0;
         hex_acc      = 32'd0;
         char_err     = 1'b0;
         byte_count   = 8'd1;
         excess       = 1'b0;
         return;
      end
      if (!in_frame) return;
      if (byte_count != 8'hFF) byte_count = byte_count + 8'd1;
      if (c == hffp_pkg::CHAR_SEP || c == hffp_pkg::CHAR_END) begin
         emitted = !excess && field_number != 3'd0;
         v = char_err ? 32'd0 : hex_acc;
         if (swap_field != 3'd0 && field_number == swap_field) begin
            v = {16'd0, v[7:0], v[15:8]};
         end
         w.index      = emitted ? field_number : 3'd0;
         w.value      = emitted ? v : 32'd0;
         w.bad        = emitted && char_err;
         w.last       = (c == hffp_pkg::CHAR_END);
         w.length_err = w.last && byte_count != expected_length;
         w.count_err  = w.last && excess;
         if (w.last) begin
            in_frame = 1'b0;
            expected_words.push_back(w);
            return;
         end
         if (!excess) begin
            if (field_number == hffp_pkg::LAST_FIELD_INDEX) begin
               excess = 1'b1;
            end else begin
               field_number = field_number + 3'd1;
            end
         end
         hex_acc  = 32'd0;
         char_err = 1'b0;
         if (emitted) expected_words.push_back(w);
         return;
      end
      digit = hex_value(c);
      if (digit[4]) begin
         hex_acc = {hex_acc[27:0], digit[3:0]};
      end else begin
         char_err = 1'b1;
      end
   endfunction

   function void report(input string what, input field_word_type want,
                        input field_word_type got);
      if (mismatches < 10) begin
         $display("%s: expected idx=%0d value=%h bad=%b last=%b len_err=%b cnt_err=%b",
                  what, want.index, want.value, want.bad, want.last,
                  want.length_err, want.count_err);
         $display("   got idx=%0d value=%h bad=%b last=%b len_err=%b cnt_err=%b",
                  got.index, got.value, got.bad, got.last, got.length_err, got.count_err);
      end
      mismatches++;
   endfunction

   function void check_word(input field_word_type got);
      field_word_type want;
      if (expected_words.size() == 0) begin
         report("unexpected word", '0, got);
         return;
      end
      want = expected_words.pop_front();
      if (got.index !== want.index || got.value !== want.value || got.bad !== want.bad ||
          got.last !== want.last || got.length_err !== want.length_err ||
          got.count_err !== want.count_err) begin
         report("field mismatch", want, got);
      end
   endfunction
endclass

module tb;

   localparam logic [7:0] ZERO_CHAR = 8'h30;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_field_index;
   logic [31:0] rsp_field_value;
   logic        rsp_field_bad;
   logic        rsp_last_field;
   logic        rsp_length_error;
   logic        rsp_count_error;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [7:0]  csr_data = 8'd0;

   field_word_checker scoreboard = new();
   int unsigned idle_pct = 0;
   int unsigned stall_pct = 0;
   logic [7:0] frame_bytes[$];

   hex_field_frame_parser u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_field_index  (rsp_field_index),
      .rsp_field_value  (rsp_field_value),
      .rsp_field_bad    (rsp_field_bad),
      .rsp_last_field   (rsp_last_field),
      .rsp_length_error (rsp_length_error),
      .rsp_count_error  (rsp_count_error),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         scoreboard.check_word({rsp_field_index, rsp_field_value, rsp_field_bad,
                                rsp_last_field, rsp_length_error, rsp_count_error});
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   task automatic send_byte(input logic [7:0] b);
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      scoreboard.take_byte(b);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (scoreboard.expected_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input hffp_pkg::csr_index_type idx, input logic [7:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      scoreboard.write_reg(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic add_field(input int unsigned n);
      logic [7:0] c;
      logic [4:0] d;
      int unsigned r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 40) begin
            c = 8'h30 + 8'($urandom_range(9));
         end else if (r < 68) begin
            c = 8'h41 + 8'($urandom_range(5));
         end else if (r < 96) begin
            c = 8'h61 + 8'($urandom_range(5));
         end else begin
            do begin
               c = 8'($urandom_range(255));
               d = scoreboard.hex_value(c);
            end while (c == hffp_pkg::CHAR_START || c == hffp_pkg::CHAR_SEP ||
                       c == hffp_pkg::CHAR_END || d[4]);
         end
         frame_bytes.push_back(c);
      end
   endtask

   function automatic int unsigned field_len();
      return ($urandom_range(9) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 8);
   endfunction

   task automatic build_frame();
      int unsigned nfields;
      int unsigned start_pos;
      int unsigned pos;
      int unsigned target;
      frame_bytes.delete();
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom_range(255)));
      end
      start_pos = frame_bytes.size();
      frame_bytes.push_back(hffp_pkg::CHAR_START);
      nfields = ($urandom_range(9) == 0) ? $urandom_range(8, 11) : $urandom_range(0, 7);
      add_field($urandom_range(0, 3));
      for (int i = 0; i < nfields; i++) begin
         frame_bytes.push_back(hffp_pkg::CHAR_SEP);
         add_field(field_len());
      end
      if ($urandom_range(19) == 0 && frame_bytes.size() > start_pos + 1) begin
         pos = $urandom_range(start_pos + 1, frame_bytes.size() - 1);
         frame_bytes.insert(pos, hffp_pkg::CHAR_START);
         start_pos = pos;
      end
      if ($urandom_range(19) == 0) return;
      if ($urandom_range(1) == 0) begin
         target = scoreboard.expected_length;
         if ($urandom_range(3) == 0) target += $urandom_range(1, 20);
         while (frame_bytes.size() - start_pos + 1 < target) frame_bytes.push_back(ZERO_CHAR);
      end
      frame_bytes.push_back(hffp_pkg::CHAR_END);
   endtask

   initial begin
      int unsigned sent;
      bit paused;
      paused = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_text("#,*x,fA09,g,,*#*:,123456789,7#");
      for (int phase = 0; phase < 10; phase++) begin
         drain();
         case (phase)
            0: begin
            end
            1: begin
               write_csr(hffp_pkg::CSR_EXPECTED_LENGTH, 8'd1);
               write_csr(hffp_pkg::CSR_SWAP_FIELD, 8'd0);
            end
            2: begin
               write_csr(hffp_pkg::CSR_EXPECTED_LENGTH, 8'd255);
               write_csr(hffp_pkg::CSR_SWAP_FIELD, 8'd7);
            end
            3: begin
               write_csr(hffp_pkg::CSR_EXPECTED_LENGTH, 8'd38);
               write_csr(hffp_pkg::CSR_SWAP_FIELD, 8'd1);
            end
            default: begin
               write_csr(hffp_pkg::CSR_EXPECTED_LENGTH, 8'($urandom_range(4, 60)));
               write_csr(hffp_pkg::CSR_SWAP_FIELD, 8'($urandom_range(0, 7)));
            end
         endcase
         case (phase % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 47; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 47; end
            default: begin idle_pct = 9; stall_pct = 9; end
         endcase
         sent = 0;
         while (sent < 125) begin
            build_frame();
            foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
            sent += frame_bytes.size();
            if (phase == 5 && !paused) begin
               drain();
               paused = 1'b1;
            end
         end
      end
      drain();
      if (scoreboard.mismatches == 0 && scoreboard.expected_words.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #1500000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/hffp_pkg.sv
hw/rtl/hex_field_frame_parser.sv
test/tb.sv
